FILE: hdl/c_string_unescape_decoder_assert.svh
// Assertion macros shared by the escape decoder modules.
`ifndef C_STRING_UNESCAPE_DECODER_ASSERT_SVH
`define C_STRING_UNESCAPE_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check a property on every rising clk edge outside of reset.
`define CUD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("escape decoder check failed");
// Check that a condition never holds outside of reset.
`define CUD_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("escape decoder forbidden condition seen");
`else
`define CUD_ASSERT(label, prop)
`define CUD_NEVER(label, cond)
`endif

`endif

FILE: hdl/cud_pkg.sv
// Shared types, codes and byte helpers of the escape decoder.
package cud_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOW_A     = 8'h61;
    localparam logic [7:0] CH_LOW_F     = 8'h66;
    localparam logic [7:0] CH_UP_A      = 8'h41;
    localparam logic [7:0] CH_UP_F      = 8'h46;
    localparam logic [7:0] CH_LOW_X     = 8'h78;
    localparam logic [7:0] CH_UP_X      = 8'h58;
    localparam logic [7:0] BYTE_MAX     = 8'hff;

    typedef enum logic [2:0] {
        MODE_TEXT      = 3'd0,
        MODE_ESC       = 3'd1,
        MODE_OCT       = 3'd2,
        MODE_HEX_FIRST = 3'd3,
        MODE_HEX       = 3'd4,
        MODE_DISCARD   = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        STATUS_OK            = 3'd0,
        STATUS_END_BACKSLASH = 3'd1,
        STATUS_END_HEX       = 3'd2,
        STATUS_BAD_HEX       = 3'd3,
        STATUS_OVER_RANGE    = 3'd4,
        STATUS_UNKNOWN_ESC   = 3'd5
    } status_t;

    // One decoded result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        status_t    status;
        logic       last_result;
    } result_t;

    // Results caused by one input word: one or two
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    function automatic result_t make_result(logic [7:0] b, logic has, status_t st,
                                            logic last);
        result_t r;
        r.out_byte    = b;
        r.has_byte    = has;
        r.status      = st;
        r.last_result = last;
        return r;
    endfunction

    function automatic logic is_oct(logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_SEVEN);
    endfunction

    function automatic logic is_hex(logic [7:0] b);
        return ((b >= CH_ZERO) && (b <= CH_NINE)) ||
               ((b >= CH_LOW_A) && (b <= CH_LOW_F)) ||
               ((b >= CH_UP_A) && (b <= CH_UP_F));
    endfunction

    function automatic logic [3:0] hex_digit(logic [7:0] b);
        logic [7:0] t;
        t = b - CH_ZERO;
        if (b >= CH_LOW_A) begin
            t = b - CH_LOW_A + 8'd10;
        end
        else if (b >= CH_UP_A) begin
            t = b - CH_UP_A + 8'd10;
        end
        return t[3:0];
    endfunction

    // Single-letter escapes: {hit, value}
    function automatic logic [8:0] esc_lookup(logic [7:0] b);
        logic [8:0] r;
        unique case (b)
            8'h61:   r = {1'b1, 8'd7};
            8'h62:   r = {1'b1, 8'd8};
            8'h66:   r = {1'b1, 8'd12};
            8'h6e:   r = {1'b1, 8'd10};
            8'h72:   r = {1'b1, 8'd13};
            8'h74:   r = {1'b1, 8'd9};
            8'h76:   r = {1'b1, 8'd11};
            8'h5c:   r = {1'b1, 8'd92};
            8'h3f:   r = {1'b1, 8'd63};
            8'h27:   r = {1'b1, 8'd39};
            8'h22:   r = {1'b1, 8'd34};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/cud_front.sv
// Front end: accepts source words, tracks escape state and builds results.
`include "c_string_unescape_decoder_assert.svh"

module cud_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     in_byte,
    input  logic           end_of_string,
    input  logic           space,
    output cud_pkg::push_t push
);
    import cud_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [8:0] acc_reg, acc_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       ovf_reg, ovf_next;
    status_t    err_reg, err_next;

    logic        accept;
    logic        b_oct, b_hex, b_bs, b_x;
    logic [3:0]  hv;
    logic [8:0]  esc;
    logic [8:0]  oct_acc;
    logic [1:0]  cnt_inc;
    logic [12:0] hex_nv;
    logic        hex_big;
    logic        e;
    logic        v0, v1;
    result_t     r0, r1;
    result_t     text_res;
    logic        text_has;

    assign in_ready = space;
    assign accept   = in_valid && in_ready;
    assign e        = end_of_string;

    // Classify the incoming byte
    assign b_oct   = is_oct(in_byte);
    assign b_hex   = is_hex(in_byte);
    assign b_bs    = (in_byte == CH_BACKSLASH);
    assign b_x     = (in_byte == CH_LOW_X) || (in_byte == CH_UP_X);
    assign hv      = hex_digit(in_byte);
    assign esc     = esc_lookup(in_byte);
    assign oct_acc = {acc_reg[5:0], in_byte[2:0]};
    assign cnt_inc = cnt_reg + 2'd1;
    assign hex_nv  = {acc_reg, 4'b0000} + {9'd0, hv};
    assign hex_big = (hex_nv[12:8] != 5'd0);

    // Plain text handling of the current byte
    always_comb
    begin
        text_has = 1'b1;
        text_res = make_result(in_byte, 1'b1, STATUS_OK, e);
        if (b_bs) begin
            text_has = e;
            text_res = make_result(8'd0, 1'b0, STATUS_END_BACKSLASH, e);
        end
    end

    // Next state
    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        err_next  = err_reg;
        unique case (mode_reg)
            MODE_TEXT: begin
                mode_next = b_bs ? MODE_ESC : MODE_TEXT;
            end
            MODE_ESC: begin
                priority if (esc[8]) begin
                    mode_next = MODE_TEXT;
                end
                else if (b_x) begin
                    mode_next = MODE_HEX_FIRST;
                end
                else if (b_oct) begin
                    mode_next = MODE_OCT;
                    acc_next  = {6'd0, in_byte[2:0]};
                    cnt_next  = 2'd1;
                end
                else begin
                    mode_next = MODE_DISCARD;
                    err_next  = STATUS_UNKNOWN_ESC;
                end
            end
            MODE_OCT: begin
                if (b_oct) begin
                    acc_next = oct_acc;
                    cnt_next = cnt_inc;
                    if (cnt_inc == 2'd3) begin
                        cnt_next = 2'd0;
                        if (oct_acc > {1'b0, BYTE_MAX}) begin
                            mode_next = MODE_DISCARD;
                            err_next  = STATUS_OVER_RANGE;
                        end
                        else begin
                            mode_next = MODE_TEXT;
                        end
                    end
                end
                else begin
                    cnt_next  = 2'd0;
                    mode_next = b_bs ? MODE_ESC : MODE_TEXT;
                end
            end
            MODE_HEX_FIRST: begin
                if (b_hex) begin
                    acc_next  = {5'd0, hv};
                    ovf_next  = 1'b0;
                    mode_next = MODE_HEX;
                end
                else begin
                    mode_next = MODE_DISCARD;
                    err_next  = STATUS_BAD_HEX;
                end
            end
            MODE_HEX: begin
                priority if (b_hex) begin
                    ovf_next = ovf_reg || hex_big;
                    acc_next = hex_nv[8:0];
                end
                else if (ovf_reg) begin
                    mode_next = MODE_DISCARD;
                    err_next  = STATUS_OVER_RANGE;
                end
                else begin
                    mode_next = b_bs ? MODE_ESC : MODE_TEXT;
                end
            end
            default: begin
                mode_next = mode_reg;
            end
        endcase
        // Return to reset state after the last byte
        if (e) begin
            mode_next = MODE_TEXT;
            acc_next  = 9'd0;
            cnt_next  = 2'd0;
            ovf_next  = 1'b0;
            err_next  = STATUS_OK;
        end
    end

    // Results of the current byte
    always_comb
    begin
        v0 = 1'b0;
        v1 = 1'b0;
        r0 = make_result(8'd0, 1'b0, STATUS_OK, 1'b0);
        r1 = make_result(8'd0, 1'b0, STATUS_OK, 1'b0);
        unique case (mode_reg)
            MODE_TEXT: begin
                v0 = text_has;
                r0 = text_res;
            end
            MODE_ESC: begin
                v0 = 1'b1;
                priority if (esc[8]) begin
                    r0 = make_result(esc[7:0], 1'b1, STATUS_OK, e);
                end
                else if (b_x) begin
                    v0 = e;
                    r0 = make_result(8'd0, 1'b0, STATUS_END_HEX, e);
                end
                else if (b_oct) begin
                    v0 = e;
                    r0 = make_result({5'd0, in_byte[2:0]}, 1'b1, STATUS_OK, e);
                end
                else begin
                    r0 = make_result(8'd0, 1'b0, STATUS_UNKNOWN_ESC, e);
                end
            end
            MODE_OCT: begin
                if (b_oct) begin
                    if (cnt_inc == 2'd3) begin
                        v0 = 1'b1;
                        if (oct_acc > {1'b0, BYTE_MAX}) begin
                            r0 = make_result(8'd0, 1'b0, STATUS_OVER_RANGE, e);
                        end
                        else begin
                            r0 = make_result(oct_acc[7:0], 1'b1, STATUS_OK, e);
                        end
                    end
                    else begin
                        v0 = e;
                        r0 = make_result(oct_acc[7:0], 1'b1, STATUS_OK, e);
                    end
                end
                else begin
                    v0 = 1'b1;
                    r0 = make_result(acc_reg[7:0], 1'b1, STATUS_OK, 1'b0);
                    v1 = text_has;
                    r1 = text_res;
                end
            end
            MODE_HEX_FIRST: begin
                if (b_hex) begin
                    v0 = e;
                    r0 = make_result({4'd0, hv}, 1'b1, STATUS_OK, e);
                end
                else begin
                    v0 = 1'b1;
                    r0 = make_result(8'd0, 1'b0, STATUS_BAD_HEX, e);
                end
            end
            MODE_HEX: begin
                priority if (b_hex) begin
                    v0 = e;
                    if (ovf_reg || hex_big) begin
                        r0 = make_result(8'd0, 1'b0, STATUS_OVER_RANGE, e);
                    end
                    else begin
                        r0 = make_result(hex_nv[7:0], 1'b1, STATUS_OK, e);
                    end
                end
                else if (ovf_reg) begin
                    v0 = 1'b1;
                    r0 = make_result(8'd0, 1'b0, STATUS_OVER_RANGE, e);
                end
                else begin
                    v0 = 1'b1;
                    r0 = make_result(acc_reg[7:0], 1'b1, STATUS_OK, 1'b0);
                    v1 = text_has;
                    r1 = text_res;
                end
            end
            default: begin
                v0 = e;
                r0 = make_result(8'd0, 1'b0, err_reg, 1'b1);
            end
        endcase
    end

    // Hand results of an accepted word to the queue
    always_comb
    begin
        push.valid     = accept && v0;
        push.entry.two = v1;
        push.entry.r0  = r0;
        push.entry.r1  = r1;
    end

    // Advance the escape state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= MODE_TEXT;
            acc_reg  <= 9'd0;
            cnt_reg  <= 2'd0;
            ovf_reg  <= 1'b0;
            err_reg  <= STATUS_OK;
        end
        else if (accept) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            err_reg  <= err_next;
        end
    end

    `CUD_ASSERT(a_discard_has_error, (mode_reg == MODE_DISCARD) |-> (err_reg != STATUS_OK))
    `CUD_ASSERT(a_end_clears_mode, (accept && e) |=> (mode_reg == MODE_TEXT))
    `CUD_ASSERT(a_end_gives_result, (accept && e) |-> push.valid)

endmodule

FILE: hdl/cud_queue.sv
// Short queue of result entries between the front and back ends.
`include "c_string_unescape_decoder_assert.svh"

module cud_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  cud_pkg::push_t  push,
    output logic            space,
    output logic            head_valid,
    output cud_pkg::entry_t head,
    input  logic            pop
);
    import cud_pkg::*;

    localparam logic [QUEUE_AW:0] DEPTH_CNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign space      = (count_reg != DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push.valid);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + (QUEUE_AW + 1)'(push.valid)
                                - (QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push.valid) begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

    `CUD_NEVER(a_no_overflow, push.valid && !space)
    `CUD_NEVER(a_no_underflow, pop && !head_valid)

endmodule

FILE: hdl/cud_back.sv
// Back end: drains queued entries one result at a time into the output register.
`include "c_string_unescape_decoder_assert.svh"

module cud_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  cud_pkg::entry_t   head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output cud_pkg::result_t  out_res
);
    import cud_pkg::*;

    logic    sel_reg, sel_next;
    logic    out_valid_reg, out_valid_next;
    result_t res_reg, res_next;
    logic    load;
    result_t cur;

    // Pick the next result of the head entry
    assign cur  = sel_reg ? head.r1 : head.r0;
    assign load = head_valid && (!out_valid_reg || out_ready);
    assign pop  = load && (sel_reg || !head.two);

    always_comb
    begin
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (load) begin
            sel_next       = !pop;
            out_valid_next = 1'b1;
            res_next       = cur;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload until taken
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    `CUD_ASSERT(a_second_pending, sel_reg |-> (head_valid && head.two))
    `CUD_ASSERT(a_error_has_status,
                (out_valid_reg && !res_reg.has_byte) |-> (res_reg.status != STATUS_OK))

endmodule

FILE: hdl/c_string_unescape_decoder.sv
// C escape sequence decoder: front end, result queue and output sequencer.
// A word's first result reaches the outputs through the result queue and the output register.
// Throughput: one word per cycle while each word gives one result and out_ready is high;
// the single output register drains one result per cycle, so two-result words fill the queue.
// Reset clears escape state, the queue and the output register; no clearing pass.
module c_string_unescape_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic [2:0] status,
    output logic       last_result
);
    import cud_pkg::*;

    push_t   push;
    logic    space;
    logic    head_valid;
    entry_t  head;
    logic    pop;
    result_t out_res;

    cud_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .space         (space),
        .push          (push)
    );

    cud_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .space      (space),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    cud_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_res    (out_res)
    );

    // Drive output fields
    assign out_byte    = out_res.out_byte;
    assign has_byte    = out_res.has_byte;
    assign status      = out_res.status;
    assign last_result = out_res.last_result;

endmodule
